// ===== src/quaternion_forward_kinematics_macros.svh =====
// Assertion macros for the kinematics RTL
`ifndef QUATERNION_FORWARD_KINEMATICS_MACROS_SVH
`define QUATERNION_FORWARD_KINEMATICS_MACROS_SVH

// same-cycle implication, needs clk and rst_n in scope
`define QFK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QFK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qfk_pkg.sv =====
// Package: widths, multiply sequence table and controller/datapath bundles
`timescale 1ns / 1ps
package qfk_pkg;

  localparam int QW   = 16;
  localparam int VW   = 32;
  localparam int TW   = 36;
  localparam int HW   = 26;
  localparam int NW   = 26;
  localparam int AW   = 27;
  localparam int BW   = 37;
  localparam int PW   = 56;
  localparam int OFW  = 43;
  localparam int RADW = 52;
  localparam int SRW  = 28;
  localparam int DRW  = 28;
  localparam int CW   = 6;

  localparam logic [CW-1:0] ROT_LAST   = 6'd14;
  localparam logic [CW-1:0] ALL_LAST   = 6'd34;
  localparam logic [CW-1:0] SQRT_ITERS = 6'd26;
  localparam logic [CW-1:0] DIV_ITERS  = 6'd16;

  // A operand sources
  localparam logic [2:0] A_Q0 = 3'd0;
  localparam logic [2:0] A_Q1 = 3'd1;
  localparam logic [2:0] A_Q2 = 3'd2;
  localparam logic [2:0] A_Q3 = 3'd3;
  localparam logic [2:0] A_H0 = 3'd4;
  localparam logic [2:0] A_H1 = 3'd5;
  localparam logic [2:0] A_H2 = 3'd6;
  localparam logic [2:0] A_H3 = 3'd7;

  // B operand sources
  localparam logic [3:0] B_V0 = 4'd0;
  localparam logic [3:0] B_V1 = 4'd1;
  localparam logic [3:0] B_V2 = 4'd2;
  localparam logic [3:0] B_T0 = 4'd3;
  localparam logic [3:0] B_T1 = 4'd4;
  localparam logic [3:0] B_T2 = 4'd5;
  localparam logic [3:0] B_R0 = 4'd6;
  localparam logic [3:0] B_R1 = 4'd7;
  localparam logic [3:0] B_R2 = 4'd8;
  localparam logic [3:0] B_R3 = 4'd9;
  localparam logic [3:0] B_H0 = 4'd10;
  localparam logic [3:0] B_H1 = 4'd11;
  localparam logic [3:0] B_H2 = 4'd12;
  localparam logic [3:0] B_H3 = 4'd13;

  // accumulator destinations
  localparam logic [3:0] D_NONE = 4'd0;
  localparam logic [3:0] D_T0   = 4'd1;
  localparam logic [3:0] D_T1   = 4'd2;
  localparam logic [3:0] D_T2   = 4'd3;
  localparam logic [3:0] D_O0   = 4'd4;
  localparam logic [3:0] D_O1   = 4'd5;
  localparam logic [3:0] D_O2   = 4'd6;
  localparam logic [3:0] D_H0   = 4'd7;
  localparam logic [3:0] D_H1   = 4'd8;
  localparam logic [3:0] D_H2   = 4'd9;
  localparam logic [3:0] D_H3   = 4'd10;
  localparam logic [3:0] D_NSQ  = 4'd11;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [3:0] b_sel;
    logic       sub;
    logic       first;
    logic       last;
    logic [3:0] dst;
  } step_t;

  typedef struct packed {
    logic          load;
    logic          mul_en;
    logic [CW-1:0] step;
    logic          sqrt_en;
    logic          div_load;
    logic          div_en;
    logic          fin;
  } cmd_t;

  typedef struct packed {
    logic is_root;
    logic given;
    logic out_free;
  } sts_t;

  function automatic step_t mk(input logic [2:0] a, input logic [3:0] b, input logic s,
                               input logic f, input logic l, input logic [3:0] d);
    step_t r;
    r.a_sel = a;
    r.b_sel = b;
    r.sub   = s;
    r.first = f;
    r.last  = l;
    r.dst   = d;
    return r;
  endfunction

  // rotation t = 2(u x v), v' = v + w t + u x t, then Hamilton product, then norm squared
  function automatic step_t step_rom(input logic [CW-1:0] idx);
    step_t r;
    case (idx)
      6'd0:    r = mk(A_Q1, B_V2, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd1:    r = mk(A_Q2, B_V1, 1'b1, 1'b0, 1'b1, D_T0);
      6'd2:    r = mk(A_Q2, B_V0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd3:    r = mk(A_Q0, B_V2, 1'b1, 1'b0, 1'b1, D_T1);
      6'd4:    r = mk(A_Q0, B_V1, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd5:    r = mk(A_Q1, B_V0, 1'b1, 1'b0, 1'b1, D_T2);
      6'd6:    r = mk(A_Q3, B_T0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd7:    r = mk(A_Q1, B_T2, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd8:    r = mk(A_Q2, B_T1, 1'b1, 1'b0, 1'b1, D_O0);
      6'd9:    r = mk(A_Q3, B_T1, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd10:   r = mk(A_Q2, B_T0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd11:   r = mk(A_Q0, B_T2, 1'b1, 1'b0, 1'b1, D_O1);
      6'd12:   r = mk(A_Q3, B_T2, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd13:   r = mk(A_Q0, B_T1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd14:   r = mk(A_Q1, B_T0, 1'b1, 1'b0, 1'b1, D_O2);
      6'd15:   r = mk(A_Q3, B_R0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd16:   r = mk(A_Q0, B_R3, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd17:   r = mk(A_Q1, B_R2, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd18:   r = mk(A_Q2, B_R1, 1'b1, 1'b0, 1'b1, D_H0);
      6'd19:   r = mk(A_Q3, B_R1, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd20:   r = mk(A_Q0, B_R2, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd21:   r = mk(A_Q1, B_R3, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd22:   r = mk(A_Q2, B_R0, 1'b0, 1'b0, 1'b1, D_H1);
      6'd23:   r = mk(A_Q3, B_R2, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd24:   r = mk(A_Q0, B_R1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd25:   r = mk(A_Q1, B_R0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd26:   r = mk(A_Q2, B_R3, 1'b0, 1'b0, 1'b1, D_H2);
      6'd27:   r = mk(A_Q3, B_R3, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd28:   r = mk(A_Q0, B_R0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd29:   r = mk(A_Q1, B_R1, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd30:   r = mk(A_Q2, B_R2, 1'b1, 1'b0, 1'b1, D_H3);
      6'd31:   r = mk(A_H0, B_H0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd32:   r = mk(A_H1, B_H1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd33:   r = mk(A_H2, B_H2, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd34:   r = mk(A_H3, B_H3, 1'b0, 1'b0, 1'b1, D_NSQ);
      default: r = mk(A_Q0, B_V0, 1'b0, 1'b1, 1'b0, D_NONE);
    endcase
    return r;
  endfunction

endpackage

// ===== src/qfk_ctrl.sv =====
// Controller: sequences load, multiply steps, square root, division and write-back
`timescale 1ns / 1ps
`include "quaternion_forward_kinematics_macros.svh"
module qfk_ctrl import qfk_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_DVI   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] mul_last;

  assign mul_last = sts.given ? ROT_LAST : ALL_LAST;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.step     = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cnt_nxt   = '0;
        state_nxt = sts.is_root ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (cnt_r == mul_last) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_nxt   = '0;
        state_nxt = sts.given ? S_FIN : S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_en = 1'b1;
        if (cnt_r == SQRT_ITERS - 1'b1) begin
          state_nxt = S_DVI;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DVI: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (cnt_r == DIV_ITERS - 1'b1) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `QFK_ASSERT_NEXT(a_accept_read, in_valid && !in_stall, state_r == S_READ, "accepted word did not start a read")
  `QFK_ASSERT_NOW(a_mul_range, state_r == S_MUL, cnt_r <= ALL_LAST, "multiply step beyond table")
  `QFK_ASSERT_NEXT(a_fin_idle, state_r == S_FIN && sts.out_free, state_r == S_IDLE, "write-back did not return to idle")

endmodule

// ===== src/qfk_dp.sv =====
// Datapath: joint store, shared multiplier, square root and division lanes, output register
`timescale 1ns / 1ps
module qfk_dp import qfk_pkg::*; #(
  parameter int MAX_JOINTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_is_root,
  input  logic                 in_last_joint,
  input  logic [4:0]           in_parent_index,
  input  logic signed [31:0]   in_vec_x,
  input  logic signed [31:0]   in_vec_y,
  input  logic signed [31:0]   in_vec_z,
  input  logic signed [15:0]   in_rot_x,
  input  logic signed [15:0]   in_rot_y,
  input  logic signed [15:0]   in_rot_z,
  input  logic signed [15:0]   in_rot_w,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  output logic signed [15:0]   out_orient_x,
  output logic signed [15:0]   out_orient_y,
  output logic signed [15:0]   out_orient_z,
  output logic signed [15:0]   out_orient_w,
  output logic                 out_joint_done_last,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int PMW = 14;
  localparam logic [JW-1:0] LAST_SLOT = JW'(MAX_JOINTS - 1);
  localparam int MW = 3 * VW + 4 * QW;

  logic                given_r;
  logic                root_r, last_r;
  logic signed [VW-1:0] v_r [3];
  logic signed [QW-1:0] rot_r [4];
  logic [MW-1:0]       mem [MAX_JOINTS];
  logic [MW-1:0]       rd_r;
  logic [JW-1:0]       jidx_r, slot;
  logic [JW-1:0]       par;
  logic [PMW-1:0]      pm;

  logic signed [VW-1:0] ppos [3];
  logic signed [QW-1:0] pq [4];

  step_t               st_i, st_a;
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [AW+BW-1:0] mul_full;
  logic signed [PW-1:0] prod_r, acc_r, base, sum;
  logic signed [PW-1:0] r8, r13, r14;
  logic                acc_vld_r;
  logic [CW-1:0]       acc_idx_r;

  logic signed [TW-1:0]  t_r [3];
  logic signed [OFW-1:0] off_r [3];
  logic signed [HW-1:0]  h_r [4];

  logic [RADW-1:0]     rad_r;
  logic [SRW-1:0]      srem_r;
  logic [NW-1:0]       root_n_r;
  logic [SRW+1:0]      sq_r2, sq_trial;

  logic [DRW-1:0]      drem_r [4];
  logic [15:0]         dlow_r [4];
  logic [15:0]         quo_r  [4];

  logic                fin_fire, out_valid_r;
  logic signed [QW-1:0] ori [4];
  logic signed [VW-1:0] pos [3];
  logic [MW-1:0]       wdata;

  // parent index reduced modulo the store depth
  always_comb begin
    pm = PMW'(in_parent_index);
    for (int i = 4; i >= 0; i--) begin
      if (pm >= (PMW'(MAX_JOINTS) << i)) begin
        pm = pm - (PMW'(MAX_JOINTS) << i);
      end
    end
    par = pm[JW-1:0];
  end

  assign slot = root_r ? '0 : jidx_r;

  always_comb begin
    ppos[0] = rd_r[MW-1 -: VW];
    ppos[1] = rd_r[MW-1-VW -: VW];
    ppos[2] = rd_r[MW-1-2*VW -: VW];
    pq[0]   = rd_r[4*QW-1 -: QW];
    pq[1]   = rd_r[3*QW-1 -: QW];
    pq[2]   = rd_r[2*QW-1 -: QW];
    pq[3]   = rd_r[QW-1 -: QW];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      root_r   <= in_is_root;
      last_r   <= in_last_joint;
      v_r[0]   <= in_vec_x;
      v_r[1]   <= in_vec_y;
      v_r[2]   <= in_vec_z;
      rot_r[0] <= in_rot_x;
      rot_r[1] <= in_rot_y;
      rot_r[2] <= in_rot_z;
      rot_r[3] <= in_rot_w;
      rd_r     <= mem[par];
    end
    if (fin_fire) begin
      mem[slot] <= wdata;
    end
  end

  // operand selection for the shared multiplier
  assign st_i = step_rom(cmd.step);
  always_comb begin
    case (st_i.a_sel)
      A_Q0:    a_op = AW'(pq[0]);
      A_Q1:    a_op = AW'(pq[1]);
      A_Q2:    a_op = AW'(pq[2]);
      A_Q3:    a_op = AW'(pq[3]);
      A_H0:    a_op = AW'(h_r[0]);
      A_H1:    a_op = AW'(h_r[1]);
      A_H2:    a_op = AW'(h_r[2]);
      A_H3:    a_op = AW'(h_r[3]);
      default: a_op = '0;
    endcase
    case (st_i.b_sel)
      B_V0:    b_op = BW'(v_r[0]);
      B_V1:    b_op = BW'(v_r[1]);
      B_V2:    b_op = BW'(v_r[2]);
      B_T0:    b_op = BW'(t_r[0]);
      B_T1:    b_op = BW'(t_r[1]);
      B_T2:    b_op = BW'(t_r[2]);
      B_R0:    b_op = BW'(rot_r[0]);
      B_R1:    b_op = BW'(rot_r[1]);
      B_R2:    b_op = BW'(rot_r[2]);
      B_R3:    b_op = BW'(rot_r[3]);
      B_H0:    b_op = BW'(h_r[0]);
      B_H1:    b_op = BW'(h_r[1]);
      B_H2:    b_op = BW'(h_r[2]);
      B_H3:    b_op = BW'(h_r[3]);
      default: b_op = '0;
    endcase
  end

  assign mul_full = a_op * b_op;

  // accumulate stage
  assign st_a = step_rom(acc_idx_r);
  assign base = st_a.first ? '0 : acc_r;
  assign sum  = st_a.sub ? (base - prod_r) : (base + prod_r);
  assign r8   = (sum + PW'(128)) >>> 8;
  assign r13  = (sum + PW'(4096)) >>> 13;
  assign r14  = (sum + PW'(8192)) >>> 14;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_full[PW-1:0];
    acc_idx_r <= cmd.step;
    if (acc_vld_r) begin
      acc_r <= sum;
    end
    if (acc_vld_r && st_a.last) begin
      case (st_a.dst)
        D_T0:  t_r[0]   <= r13[TW-1:0];
        D_T1:  t_r[1]   <= r13[TW-1:0];
        D_T2:  t_r[2]   <= r13[TW-1:0];
        D_O0:  off_r[0] <= OFW'(v_r[0]) + r14[OFW-1:0];
        D_O1:  off_r[1] <= OFW'(v_r[1]) + r14[OFW-1:0];
        D_O2:  off_r[2] <= OFW'(v_r[2]) + r14[OFW-1:0];
        D_H0:  h_r[0]   <= r8[HW-1:0];
        D_H1:  h_r[1]   <= r8[HW-1:0];
        D_H2:  h_r[2]   <= r8[HW-1:0];
        D_H3:  h_r[3]   <= r8[HW-1:0];
        default: begin
        end
      endcase
    end
  end

  // square root, one result bit per cycle
  assign sq_r2    = {srem_r, rad_r[RADW-1 -: 2]};
  assign sq_trial = (SRW+2)'({root_n_r, 2'b01});

  always_ff @(posedge clk) begin
    if (acc_vld_r && st_a.last && (st_a.dst == D_NSQ)) begin
      rad_r    <= sum[RADW-1:0];
      srem_r   <= '0;
      root_n_r <= '0;
    end else if (cmd.sqrt_en) begin
      rad_r <= rad_r << 2;
      if (sq_r2 >= sq_trial) begin
        srem_r   <= SRW'(sq_r2 - sq_trial);
        root_n_r <= {root_n_r[NW-2:0], 1'b1};
      end else begin
        srem_r   <= sq_r2[SRW-1:0];
        root_n_r <= {root_n_r[NW-2:0], 1'b0};
      end
    end
  end

  // four restoring division lanes: round(|h| * 2^14 / n)
  always_ff @(posedge clk) begin
    logic [HW-1:0]  mag;
    logic [41:0]    dvd;
    logic [DRW:0]   r2;
    logic [DRW:0]   dv;
    for (int i = 0; i < 4; i++) begin
      mag = h_r[i][HW-1] ? HW'(-h_r[i]) : HW'(h_r[i]);
      dvd = 42'({mag, 15'b0}) + 42'(root_n_r);
      r2  = {drem_r[i], dlow_r[i][15]};
      dv  = (DRW+1)'({root_n_r, 1'b0});
      if (cmd.div_load) begin
        drem_r[i] <= DRW'(dvd[41:16]);
        dlow_r[i] <= dvd[15:0];
        quo_r[i]  <= '0;
      end else if (cmd.div_en) begin
        dlow_r[i] <= dlow_r[i] << 1;
        if (r2 >= dv) begin
          drem_r[i] <= DRW'(r2 - dv);
          quo_r[i]  <= {quo_r[i][14:0], 1'b1};
        end else begin
          drem_r[i] <= r2[DRW-1:0];
          quo_r[i]  <= {quo_r[i][14:0], 1'b0};
        end
      end
    end
  end

  // write-back values
  always_comb begin
    logic signed [OFW-1:0] ps;
    for (int i = 0; i < 4; i++) begin
      if (root_r || given_r) begin
        ori[i] = rot_r[i];
      end else if (root_n_r == '0) begin
        ori[i] = '0;
      end else if (h_r[i][HW-1]) begin
        ori[i] = -$signed(quo_r[i]);
      end else begin
        ori[i] = $signed(quo_r[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      ps = OFW'(ppos[i]) + off_r[i];
      if (root_r) begin
        pos[i] = v_r[i];
      end else if (ps > OFW'(32'sh7FFFFFFF)) begin
        pos[i] = 32'sh7FFFFFFF;
      end else if (ps < OFW'(-33'sh80000000)) begin
        pos[i] = -32'sh80000000;
      end else begin
        pos[i] = ps[VW-1:0];
      end
    end
  end

  assign wdata = {pos[0], pos[1], pos[2], ori[0], ori[1], ori[2], ori[3]};

  assign fin_fire = cmd.fin && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      given_r     <= 1'b0;
      jidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        given_r <= cfg_wdata;
      end
      if (fin_fire) begin
        jidx_r      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_pos_x           <= pos[0];
      out_pos_y           <= pos[1];
      out_pos_z           <= pos[2];
      out_orient_x        <= ori[0];
      out_orient_y        <= ori[1];
      out_orient_z        <= ori[2];
      out_orient_w        <= ori[3];
      out_joint_done_last <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.is_root  = root_r;
  assign sts.given    = given_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== src/quaternion_forward_kinematics.sv =====
// Top level: skeleton forward kinematics, controller plus datapath
//
//   channel   direction  handshake          word
//   in_*      input      in_valid/in_stall  one joint: flags, parent, offset, quaternion
//   out_*     output     out_valid/out_stall one joint pose: position, orientation, last flag
//   cfg_*     input      cfg_we             orientation_given bit
//
// Root joint: written back straight after the read, with no products. Non-root joint with
// orientation given: the 15 rotation products through the one shared multiplier. Composed
// orientation: 35 products, then a square root and four division lanes.
// Synchronous active-low reset; the joint store is not cleared.
// A waiting result holds the output register; the next word is still accepted.
`timescale 1ns / 1ps
module quaternion_forward_kinematics import qfk_pkg::*; #(
  parameter int MAX_JOINTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_is_root,
  input  logic               in_last_joint,
  input  logic [4:0]         in_parent_index,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [15:0] in_rot_x,
  input  logic signed [15:0] in_rot_y,
  input  logic signed [15:0] in_rot_z,
  input  logic signed [15:0] in_rot_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_orient_x,
  output logic signed [15:0] out_orient_y,
  output logic signed [15:0] out_orient_z,
  output logic signed [15:0] out_orient_w,
  output logic               out_joint_done_last
);

  cmd_t cmd;
  sts_t sts;

  qfk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qfk_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_is_root          (in_is_root),
    .in_last_joint       (in_last_joint),
    .in_parent_index     (in_parent_index),
    .in_vec_x            (in_vec_x),
    .in_vec_y            (in_vec_y),
    .in_vec_z            (in_vec_z),
    .in_rot_x            (in_rot_x),
    .in_rot_y            (in_rot_y),
    .in_rot_z            (in_rot_z),
    .in_rot_w            (in_rot_w),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pos_x           (out_pos_x),
    .out_pos_y           (out_pos_y),
    .out_pos_z           (out_pos_z),
    .out_orient_x        (out_orient_x),
    .out_orient_y        (out_orient_y),
    .out_orient_z        (out_orient_z),
    .out_orient_w        (out_orient_w),
    .out_joint_done_last (out_joint_done_last),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

// ===== tb/sv/tb_quaternion_forward_kinematics.sv =====
// Testbench for quaternion_forward_kinematics: directed and random skeletons checked against a pose predictor
`timescale 1ns / 1ps
module tb_quaternion_forward_kinematics;
  import qfk_pkg::*;

  localparam int NJ = 32;
  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    bit              is_root;
    bit              last;
    bit [4:0]        parent;
    bit signed [31:0] vx, vy, vz;
    bit signed [15:0] rx, ry, rz, rw;
  } joint_t;

  typedef struct {
    bit signed [31:0] px, py, pz;
    bit signed [15:0] ox, oy, oz, ow;
    bit              last;
  } pose_t;

  class pose_board;
    bit               given;
    bit [4:0]         next_slot;
    bit               written[NJ];
    bit signed [31:0] pos_x[NJ], pos_y[NJ], pos_z[NJ];
    bit signed [15:0] orient[NJ][4];
    pose_t            pending_poses[$];
    int               errors;

    function longint rnd(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint sat(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000000000000000;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint div_round(longint a, longint n);
      longint m, q;
      m = a < 0 ? -a : a;
      q = (2 * m + n) / (2 * n);
      return a < 0 ? -q : q;
    endfunction

    function void note(joint_t j);
      longint v[3], r[4], q[4], t[3], d[3], o[3], h[4], p[3], ori[4], n;
      longint unsigned nsq;
      bit [4:0] slot, par;
      pose_t e;
      slot = j.is_root ? 5'd0 : next_slot;
      par = j.parent;
      v = '{longint'(j.vx), longint'(j.vy), longint'(j.vz)};
      r = '{longint'(j.rx), longint'(j.ry), longint'(j.rz), longint'(j.rw)};
      if (j.is_root) begin
        p = v;
        ori = r;
      end else begin
        for (int i = 0; i < 4; i++) q[i] = orient[par][i];
        t[0] = rnd(2 * (q[1] * v[2] - q[2] * v[1]), 14);
        t[1] = rnd(2 * (q[2] * v[0] - q[0] * v[2]), 14);
        t[2] = rnd(2 * (q[0] * v[1] - q[1] * v[0]), 14);
        d[0] = q[1] * t[2] - q[2] * t[1];
        d[1] = q[2] * t[0] - q[0] * t[2];
        d[2] = q[0] * t[1] - q[1] * t[0];
        for (int i = 0; i < 3; i++) o[i] = v[i] + rnd(q[3] * t[i] + d[i], 14);
        p[0] = sat(longint'(pos_x[par]) + o[0], -(64'sd1 << 31), (64'sd1 << 31) - 1);
        p[1] = sat(longint'(pos_y[par]) + o[1], -(64'sd1 << 31), (64'sd1 << 31) - 1);
        p[2] = sat(longint'(pos_z[par]) + o[2], -(64'sd1 << 31), (64'sd1 << 31) - 1);
        if (given) begin
          ori = r;
        end else begin
          h[0] = q[3] * r[0] + q[0] * r[3] + q[1] * r[2] - q[2] * r[1];
          h[1] = q[3] * r[1] - q[0] * r[2] + q[1] * r[3] + q[2] * r[0];
          h[2] = q[3] * r[2] + q[0] * r[1] - q[1] * r[0] + q[2] * r[3];
          h[3] = q[3] * r[3] - q[0] * r[0] - q[1] * r[1] - q[2] * r[2];
          nsq = 0;
          for (int i = 0; i < 4; i++) begin
            h[i] = rnd(h[i], 8);
            nsq += h[i] * h[i];
          end
          n = isqrt(nsq);
          for (int i = 0; i < 4; i++)
            ori[i] = (n == 0) ? 0 : sat(div_round(h[i] * 16384, n), -32768, 32767);
        end
      end
      pos_x[slot] = p[0];
      pos_y[slot] = p[1];
      pos_z[slot] = p[2];
      for (int i = 0; i < 4; i++) orient[slot][i] = ori[i];
      written[slot] = 1;
      next_slot = slot + 5'd1;
      e.px = p[0]; e.py = p[1]; e.pz = p[2];
      e.ox = ori[0]; e.oy = ori[1]; e.oz = ori[2]; e.ow = ori[3];
      e.last = j.last;
      pending_poses.push_back(e);
    endfunction

    function void check(pose_t a);
      pose_t e;
      if (pending_poses.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending_poses.pop_front();
      if (a.px != e.px) begin $error("pos_x exp %0d got %0d", e.px, a.px); errors++; end
      if (a.py != e.py) begin $error("pos_y exp %0d got %0d", e.py, a.py); errors++; end
      if (a.pz != e.pz) begin $error("pos_z exp %0d got %0d", e.pz, a.pz); errors++; end
      if (a.ox != e.ox) begin $error("orient_x exp %0d got %0d", e.ox, a.ox); errors++; end
      if (a.oy != e.oy) begin $error("orient_y exp %0d got %0d", e.oy, a.oy); errors++; end
      if (a.oz != e.oz) begin $error("orient_z exp %0d got %0d", e.oz, a.oz); errors++; end
      if (a.ow != e.ow) begin $error("orient_w exp %0d got %0d", e.ow, a.ow); errors++; end
      if (a.last != e.last) begin
        $error("joint_done_last exp %0d got %0d", e.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic               cfg_wdata = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               in_is_root = 0;
  logic               in_last_joint = 0;
  logic [4:0]         in_parent_index = 0;
  logic signed [31:0] in_vec_x = 0, in_vec_y = 0, in_vec_z = 0;
  logic signed [15:0] in_rot_x = 0, in_rot_y = 0, in_rot_z = 0, in_rot_w = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_orient_x, out_orient_y, out_orient_z, out_orient_w;
  logic               out_joint_done_last;

  pose_board sb = new();
  int burst_left = 1;
  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int sent = 0;

  quaternion_forward_kinematics uut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    pose_t a;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        a.px = out_pos_x; a.py = out_pos_y; a.pz = out_pos_z;
        a.ox = out_orient_x; a.oy = out_orient_y; a.oz = out_orient_z; a.ow = out_orient_w;
        a.last = out_joint_done_last;
        sb.check(a);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(joint_t j);
    int gap;
    @(negedge clk);
    in_is_root <= j.is_root;
    in_last_joint <= j.last;
    in_parent_index <= j.parent;
    in_vec_x <= j.vx; in_vec_y <= j.vy; in_vec_z <= j.vz;
    in_rot_x <= j.rx; in_rot_y <= j.ry; in_rot_z <= j.rz; in_rot_w <= j.rw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(j);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic set_given(bit v);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (sb.pending_poses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.given = v;
  endtask

  function automatic bit signed [31:0] rand_vec();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 255)
                                          : 32'sh80000000 + $urandom_range(0, 255);
      default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  function automatic joint_t rand_rot(joint_t j);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      j.rx = 0; j.ry = 0; j.rz = 0; j.rw = 0;
    end else if (k < 4) begin
      j.rx = $urandom; j.ry = $urandom; j.rz = $urandom; j.rw = $urandom;
    end else begin
      j.rx = $signed($urandom_range(0, 16384)) - 8192;
      j.ry = $signed($urandom_range(0, 16384)) - 8192;
      j.rz = $signed($urandom_range(0, 16384)) - 8192;
      j.rw = $signed($urandom_range(0, 32768)) - 16384;
    end
    return j;
  endfunction

  function automatic bit [4:0] rand_written();
    bit [4:0] s;
    do s = $urandom_range(0, NJ - 1); while (!sb.written[s]);
    return s;
  endfunction

  task automatic skeleton(int n);
    joint_t j;
    bit [4:0] root_slot;
    for (int k = 0; k < n; k++) begin
      j.is_root = (k == 0);
      j.last = (k == n - 1) ^ ($urandom_range(0, 19) == 0);
      j.vx = rand_vec(); j.vy = rand_vec(); j.vz = rand_vec();
      j = rand_rot(j);
      if (k == 0) begin
        j.parent = $urandom;
      end else begin
        case ($urandom_range(0, 9))
          0:       j.parent = rand_written();
          1:       j.parent = sb.written[sb.next_slot] ? sb.next_slot : rand_written();
          default: j.parent = $urandom_range(0, k - 1);
        endcase
      end
      send(j);
    end
  endtask

  function automatic joint_t mk_joint(bit root, bit last, bit [4:0] par,
                                      int vx, int vy, int vz,
                                      int rx, int ry, int rz, int rw);
    joint_t j;
    j.is_root = root; j.last = last; j.parent = par;
    j.vx = vx; j.vy = vy; j.vz = vz;
    j.rx = rx; j.ry = ry; j.rz = rz; j.rw = rw;
    return j;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_given(1'b0);

    // extremes, saturation, zero-norm parent, parent equal to own slot
    send(mk_joint(1, 0, 31, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 16384));
    send(mk_joint(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 16384));
    send(mk_joint(0, 0, 0, 65536, -65536, 131072, 11585, 0, 0, 11585));
    send(mk_joint(0, 0, 2, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  -32768, -32768, -32768, -32768));
    send(mk_joint(0, 0, 3, 1, -1, 12345, 32767, 32767, 32767, 32767));
    send(mk_joint(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk_joint(0, 0, 0, 1000, 2000, 3000, 100, -200, 300, 16384));
    send(mk_joint(0, 0, 2, -5, 7, -9, -32768, 32767, 0, 1));
    send(mk_joint(0, 1, 3, 65536, 65536, 65536, 0, 16384, 0, 0));
    send(mk_joint(0, 0, 4, 123456, -654321, 42, 16384, 0, 0, 0));
    send(mk_joint(1, 0, 0, -1000, 0, 1000, 0, 0, 16384, 0));
    send(mk_joint(0, 1, 1, 77, 88, 99, 0, 0, 0, 16384));
    set_given(1'b1);
    send(mk_joint(1, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32767, 0, 0, 0));
    send(mk_joint(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  -32768, 32767, -32768, 32767));
    send(mk_joint(0, 0, 1, -65536, 65536, 0, 0, 0, 0, 0));
    send(mk_joint(0, 1, 2, 1, 2, 3, 1, 2, 3, 4));

    for (int ph = 0; ph < 6; ph++) begin
      set_given(ph[0]);
      while (sent < 16 + (ph + 1) * 225) begin
        if ($urandom_range(0, 15) == 0) skeleton(NJ);
        else skeleton($urandom_range(1, 12));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (sb.pending_poses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/qfk_pkg.sv
src/qfk_ctrl.sv
src/qfk_dp.sv
src/quaternion_forward_kinematics.sv
tb/sv/tb_quaternion_forward_kinematics.sv
